@@ rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the alphabet lookup for the streaming base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// result status codes
	localparam logic [1:0] ST_DATA = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [6:0] NOT_SEXTET = 7'd64;

	// run mode, one-hot
	typedef enum logic [2:0] {
		MODE_DECODING = 3'b001,
		MODE_STOPPED  = 3'b010,
		MODE_ERROR    = 3'b100
	} mode_t;

	// decoder state carried from item to item
	typedef struct packed {
		logic [1:0]  pos;
		logic [17:0] acc;
		logic [1:0]  pads;
		mode_t       mode;
	} dec_state_t;

	// everything one item produces
	typedef struct packed {
		dec_state_t  nxt;
		logic [23:0] val;
		logic [1:0]  nbytes;
		logic        has_close;
		logic        close_err;
	} dec_result_t;

	// sextet of an alphabet character, NOT_SEXTET otherwise
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			d = 8'd62;
		end else if (c == 8'h2F) begin
			d = 8'd63;
		end else begin
			d = {1'b0, NOT_SEXTET};
		end
		return d[6:0];
	endfunction

endpackage

@@ rtl/b64d_decode.sv @@
// ----------------------------------------------------------------------------
// b64d_decode
// Combinational step: one character against the current state gives the next
// state and the bytes and closing result that the character causes.
// ----------------------------------------------------------------------------
module b64d_decode (
	input  logic [7:0]              in_char,
	input  logic                    end_of_string,
	input  b64d_pkg::dec_state_t    cur,
	output b64d_pkg::dec_result_t   res
);

	logic [6:0]  sx_raw;
	logic        not_sx;
	logic        is_pad;
	logic [5:0]  sx;
	logic [1:0]  pads_n;
	logic        decoding;
	b64d_pkg::dec_state_t nxt;

	assign sx_raw = b64d_pkg::sextet_of(in_char);
	assign not_sx = (sx_raw == b64d_pkg::NOT_SEXTET);
	assign is_pad = (in_char == b64d_pkg::PAD_CHAR);
	assign sx     = is_pad ? 6'd0 : sx_raw[5:0];
	assign pads_n = is_pad ? cur.pads + 2'd1 : cur.pads;

	// modes other than decoding ignore the character; unused code acts as error
	always_comb begin
		unique case (cur.mode)
			b64d_pkg::MODE_DECODING: decoding = 1'b1;
			b64d_pkg::MODE_STOPPED:  decoding = 1'b0;
			b64d_pkg::MODE_ERROR:    decoding = 1'b0;
			default:                 decoding = 1'b0;
		endcase
	end

	// next state and group output
	always_comb begin
		nxt            = cur;
		res.val        = 24'd0;
		res.nbytes     = 2'd0;
		if (decoding) begin
			if (cur.pos == 2'd0 && not_sx && !is_pad) begin
				nxt.mode = b64d_pkg::MODE_STOPPED;
			end else if (is_pad && cur.pads >= 2'd2) begin
				nxt.mode = b64d_pkg::MODE_ERROR;
			end else if (!is_pad && (cur.pads != 2'd0 || not_sx)) begin
				nxt.mode = b64d_pkg::MODE_ERROR;
			end else if (cur.pos == 2'd3) begin
				// group complete
				res.val    = {cur.acc, sx};
				res.nbytes = 2'd3 - pads_n;
				nxt.pos    = 2'd0;
				nxt.acc    = 18'd0;
				nxt.pads   = 2'd0;
			end else begin
				nxt.acc  = {cur.acc[11:0], sx};
				nxt.pos  = cur.pos + 2'd1;
				nxt.pads = pads_n;
			end
			// string ends inside a group
			if (end_of_string && nxt.mode == b64d_pkg::MODE_DECODING && nxt.pos != 2'd0) begin
				nxt.mode = b64d_pkg::MODE_ERROR;
			end
		end

		res.has_close = end_of_string;
		res.close_err = !(nxt.mode == b64d_pkg::MODE_DECODING ||
		                  nxt.mode == b64d_pkg::MODE_STOPPED);

		// closing result returns everything to reset
		if (end_of_string) begin
			nxt.pos  = 2'd0;
			nxt.acc  = 18'd0;
			nxt.pads = 2'd0;
			nxt.mode = b64d_pkg::MODE_DECODING;
		end
		res.nxt = nxt;
	end

endmodule

@@ rtl/base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: characters in, decoded bytes and a closing status
// out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one character per item, with
//   end_of_string set on the final character of a string. Output channel
//   (out_valid/out_ready) gives one result per item: a data byte (status
//   data), or the closing result (status ok or error) after the final char.
//   run_last marks the last result caused by one input item.
//   The first result of an item is registered: the item passes the input
//   register, then the result register, waiting while that is not free.
//   Throughput: one character per cycle while none waits in the input
//   register. A character that causes results moves into the result
//   register only when that register is free or is giving its last
//   result; the fourth character of a group holds up to four results,
//   drained at one result per cycle while out_ready is high. Characters
//   that cause no result pass while results drain.
//   Reset: clears the valid flags, result index and decoder state.
//   When the receiver stalls, the result register holds, the next
//   character that causes results waits in the input register, and
//   in_ready drops.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       run_last
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;

	// decoder state
	b64d_pkg::dec_state_t  state_q;
	b64d_pkg::dec_result_t dec;

	// result register: up to three bytes plus a closing result
	logic        res_valid_s2;
	logic [23:0] res_val_s2;
	logic [1:0]  res_nbytes_s2;
	logic        res_close_s2;
	logic        res_err_s2;
	logic [1:0]  res_idx_q;

	logic [2:0]  res_total;
	logic        res_last;
	logic        res_done;
	logic        res_free;
	logic        dec_has_out;
	logic        adv_s1;

	b64d_decode u_decode (
		.in_char       (char_s1),
		.end_of_string (eos_s1),
		.cur           (state_q),
		.res           (dec)
	);

	// handshake control
	assign res_total   = {1'b0, res_nbytes_s2} + {2'b00, res_close_s2};
	assign res_last    = ({1'b0, res_idx_q} + 3'd1) == res_total;
	assign res_done    = res_valid_s2 && out_ready && res_last;
	assign res_free    = !res_valid_s2 || res_done;
	assign dec_has_out = (dec.nbytes != 2'd0) || dec.has_close;
	assign adv_s1      = valid_s1 && (!dec_has_out || res_free);
	assign in_ready    = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			eos_s1  <= end_of_string;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pos  <= 2'd0;
			state_q.acc  <= 18'd0;
			state_q.pads <= 2'd0;
			state_q.mode <= b64d_pkg::MODE_DECODING;
		end else if (adv_s1) begin
			state_q <= dec.nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
			res_idx_q    <= 2'd0;
		end else if (adv_s1 && dec_has_out) begin
			res_valid_s2 <= 1'b1;
			res_idx_q    <= 2'd0;
		end else if (res_done) begin
			res_valid_s2 <= 1'b0;
			res_idx_q    <= 2'd0;
		end else if (res_valid_s2 && out_ready) begin
			res_idx_q <= res_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && dec_has_out) begin
			res_val_s2    <= dec.val;
			res_nbytes_s2 <= dec.nbytes;
			res_close_s2  <= dec.has_close;
			res_err_s2    <= dec.close_err;
		end
	end

	// result select
	always_comb begin
		out_valid = res_valid_s2;
		run_last  = res_last;
		if (res_idx_q < res_nbytes_s2) begin
			status = b64d_pkg::ST_DATA;
			case (res_idx_q)
				2'd0:    out_byte = res_val_s2[23:16];
				2'd1:    out_byte = res_val_s2[15:8];
				default: out_byte = res_val_s2[7:0];
			endcase
		end else begin
			out_byte = 8'd0;
			status   = res_err_s2 ? b64d_pkg::ST_ERR : b64d_pkg::ST_OK;
		end
	end

`ifndef NO_ASSERTIONS
	// index stays inside the held results
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> ({1'b0, res_idx_q} < res_total))
		else $error("result index past held results");

	// a held entry always has something to give
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> (res_total != 3'd0))
		else $error("empty result entry");

	// closing result is always the last of its item and carries no byte
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != b64d_pkg::ST_DATA) |-> (run_last && out_byte == 8'd0))
		else $error("closing result not last or has a byte");

	// a final character returns the state to reset
	a_eos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eos_s1) |=> (state_q.pos == 2'd0 && state_q.pads == 2'd0 &&
		                        state_q.mode == b64d_pkg::MODE_DECODING))
		else $error("state not cleared after final character");

	// results never overwritten before delivered
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && dec_has_out) |-> res_free)
		else $error("result register overwritten");
`endif

endmodule
